### hw/rtl/mqttpf_pkg.sv
// Package for the MQTT PUBLISH framer: action codes, phase and step types,
// the command record passed from front to back, and size constants.
// No dependencies.
package mqttpf_pkg;

    // input action codes
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_TOPIC   = 2'd1;
    localparam logic [1:0] ACT_PAYLOAD = 2'd2;

    // size limits
    localparam logic [28:0] REM_MAX        = 29'd268435455;
    localparam logic [28:0] VLI_LIM1       = 29'd128;
    localparam logic [28:0] VLI_LIM2       = 29'd16384;
    localparam logic [28:0] VLI_LIM3       = 29'd2097152;
    localparam logic [28:0] MAX_LEN_RESET  = 29'd1024;
    localparam logic [3:0]  PUBLISH_TYPE   = 4'h3;
    localparam int          CMD_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TOPIC   = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CMD_ERR   = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_HDR     = 3'd0,
        ST_LEN     = 3'd1,
        ST_TLEN_HI = 3'd2,
        ST_TLEN_LO = 3'd3,
        ST_PID_HI  = 3'd4,
        ST_PID_LO  = 3'd5,
        ST_DATA    = 3'd6,
        ST_ERR     = 3'd7
    } step_t;

    // one queued command: the bytes it expands to are set by kind
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  hdr_byte;
        logic [27:0] rem;       // remaining length
        logic [1:0]  nlen;      // length field bytes minus one
        logic [15:0] tlen;
        logic [7:0]  data;
        logic        send_pid;  // packet id follows this command's bytes
        logic [15:0] pid;
        logic        pkt_end;   // final byte of this command ends the packet
    } cmd_t;

endpackage

### hw/rtl/mqttpf_front.sv
// Front end of the MQTT PUBLISH framer: accepts input items, tracks the
// packet phase, checks size and pushes commands to the queue.
// Depends on mqttpf_pkg.
module mqttpf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [28:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic                 dup_flag,
    input  logic [1:0]           qos_level,
    input  logic                 retain_flag,
    input  logic [15:0]          packet_id,
    input  logic [15:0]          topic_length,
    input  logic [27:0]          payload_length,
    input  logic [7:0]           data_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output mqttpf_pkg::cmd_t     q_cmd
);

    logic [28:0]          max_len_reg;
    mqttpf_pkg::phase_t   phase_reg, phase_next;
    logic [15:0]          tleft_reg, tleft_next;
    logic [27:0]          pleft_reg, pleft_next;
    logic [15:0]          pid_reg, pid_next;
    logic                 qnz_reg, qnz_next;

    logic                 accept;
    logic                 qos_nz;
    logic [28:0]          rem;
    logic [1:0]           nlen;
    logic [29:0]          total;
    logic                 too_long;
    logic [15:0]          tleft_dec;
    logic [27:0]          pleft_dec;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    // size of a new packet
    assign qos_nz = (qos_level != 2'd0);
    assign rem    = 29'd2 + 29'(topic_length) + 29'(payload_length)
                    + (qos_nz ? 29'd2 : 29'd0);
    always_comb
    begin
        if (rem < mqttpf_pkg::VLI_LIM1)
            nlen = 2'd0;
        else if (rem < mqttpf_pkg::VLI_LIM2)
            nlen = 2'd1;
        else if (rem < mqttpf_pkg::VLI_LIM3)
            nlen = 2'd2;
        else
            nlen = 2'd3;
    end
    // whole packet = 1 + field bytes + rem = rem + nlen + 2
    assign total    = 30'(rem) + 30'(nlen) + 30'd2;
    assign too_long = (rem > mqttpf_pkg::REM_MAX) || (total > 30'(max_len_reg));

    assign tleft_dec = tleft_reg - 16'd1;
    assign pleft_dec = pleft_reg - 28'd1;

    // classify the item and build its command
    always_comb
    begin
        phase_next = phase_reg;
        tleft_next = tleft_reg;
        pleft_next = pleft_reg;
        pid_next   = pid_reg;
        qnz_next   = qnz_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        q_cmd.hdr_byte = {mqttpf_pkg::PUBLISH_TYPE, dup_flag, qos_level, retain_flag};
        q_cmd.rem      = rem[27:0];
        q_cmd.nlen     = nlen;
        q_cmd.tlen     = topic_length;
        q_cmd.data     = data_byte;
        if (accept)
        begin
            case (action)
                mqttpf_pkg::ACT_START:
                begin
                    q_push = 1'b1;
                    if (too_long)
                    begin
                        q_cmd.kind    = mqttpf_pkg::CMD_ERR;
                        q_cmd.pkt_end = 1'b1;
                        phase_next    = mqttpf_pkg::PH_IDLE;
                    end
                    else
                    begin
                        q_cmd.kind     = mqttpf_pkg::CMD_START;
                        q_cmd.pid      = packet_id;
                        q_cmd.send_pid = (topic_length == 16'd0) && qos_nz;
                        q_cmd.pkt_end  = (topic_length == 16'd0) && (payload_length == 28'd0);
                        tleft_next = topic_length;
                        pleft_next = payload_length;
                        pid_next   = packet_id;
                        qnz_next   = qos_nz;
                        if (topic_length != 16'd0)
                            phase_next = mqttpf_pkg::PH_TOPIC;
                        else if (payload_length != 28'd0)
                            phase_next = mqttpf_pkg::PH_PAYLOAD;
                        else
                            phase_next = mqttpf_pkg::PH_IDLE;
                    end
                end
                mqttpf_pkg::ACT_TOPIC:
                begin
                    if (phase_reg == mqttpf_pkg::PH_TOPIC)
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = mqttpf_pkg::CMD_DATA;
                        q_cmd.pid  = pid_reg;
                        tleft_next = tleft_dec;
                        if (tleft_dec == 16'd0)
                        begin
                            q_cmd.send_pid = qnz_reg;
                            q_cmd.pkt_end  = (pleft_reg == 28'd0);
                            phase_next = (pleft_reg != 28'd0) ? mqttpf_pkg::PH_PAYLOAD
                                                              : mqttpf_pkg::PH_IDLE;
                        end
                    end
                end
                mqttpf_pkg::ACT_PAYLOAD:
                begin
                    if (phase_reg == mqttpf_pkg::PH_PAYLOAD)
                    begin
                        q_push        = 1'b1;
                        q_cmd.kind    = mqttpf_pkg::CMD_DATA;
                        q_cmd.pkt_end = (pleft_dec == 28'd0);
                        pleft_next    = pleft_dec;
                        if (pleft_dec == 28'd0)
                            phase_next = mqttpf_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= mqttpf_pkg::MAX_LEN_RESET;
            phase_reg   <= mqttpf_pkg::PH_IDLE;
            tleft_reg   <= '0;
            pleft_reg   <= '0;
            pid_reg     <= '0;
            qnz_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
            phase_reg <= phase_next;
            tleft_reg <= tleft_next;
            pleft_reg <= pleft_next;
            pid_reg   <= pid_next;
            qnz_reg   <= qnz_next;
        end
    end

endmodule

### hw/rtl/mqttpf_cmd_fifo.sv
// Command queue between front and back of the MQTT PUBLISH framer.
// Small register FIFO with head shown combinationally. Depends on mqttpf_pkg.
module mqttpf_cmd_fifo #(
    parameter int DEPTH = mqttpf_pkg::CMD_FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mqttpf_pkg::cmd_t     push_cmd,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output mqttpf_pkg::cmd_t     head_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mqttpf_pkg::cmd_t  mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("command queue pop while empty");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + CW'($past(push)) - CW'($past(pop)))
        else $error("command queue count out of step");

endmodule

### hw/rtl/mqttpf_back.sv
// Back end of the MQTT PUBLISH framer: expands queued commands into bytes,
// one per unstalled cycle, into an output register. Depends on mqttpf_pkg.
module mqttpf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  mqttpf_pkg::cmd_t     q_cmd,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 last_byte,
    output logic                 too_long
);

    logic                 busy_reg, busy_next;
    mqttpf_pkg::step_t    step_reg, step_next;
    logic [1:0]           lidx_reg, lidx_next;
    logic                 ov_reg;
    logic [7:0]           ob_reg;
    logic                 ol_reg;
    logic                 ot_reg;

    mqttpf_pkg::step_t    cur_step;
    logic [1:0]           cur_lidx;
    logic                 fire;
    logic                 done;
    logic [7:0]           byte_v;
    logic [6:0]           rem_slice;

    assign fire = q_valid && (!ov_reg || out_ready);

    // step at which the head command stands
    always_comb
    begin
        if (busy_reg)
        begin
            cur_step = step_reg;
            cur_lidx = lidx_reg;
        end
        else
        begin
            cur_lidx = 2'd0;
            case (q_cmd.kind)
                mqttpf_pkg::CMD_START: cur_step = mqttpf_pkg::ST_HDR;
                mqttpf_pkg::CMD_DATA:  cur_step = mqttpf_pkg::ST_DATA;
                default:               cur_step = mqttpf_pkg::ST_ERR;
            endcase
        end
    end

    // 7-bit group of the remaining length, low group first
    always_comb
    begin
        case (cur_lidx)
            2'd0:    rem_slice = q_cmd.rem[6:0];
            2'd1:    rem_slice = q_cmd.rem[13:7];
            2'd2:    rem_slice = q_cmd.rem[20:14];
            default: rem_slice = q_cmd.rem[27:21];
        endcase
    end

    // byte for this step and the step after it
    always_comb
    begin
        step_next = cur_step;
        lidx_next = cur_lidx;
        done      = 1'b0;
        byte_v    = 8'd0;
        case (cur_step)
            mqttpf_pkg::ST_HDR:
            begin
                byte_v    = q_cmd.hdr_byte;
                step_next = mqttpf_pkg::ST_LEN;
                lidx_next = 2'd0;
            end
            mqttpf_pkg::ST_LEN:
            begin
                byte_v = {(cur_lidx != q_cmd.nlen), rem_slice};
                if (cur_lidx == q_cmd.nlen)
                    step_next = mqttpf_pkg::ST_TLEN_HI;
                else
                    lidx_next = cur_lidx + 2'd1;
            end
            mqttpf_pkg::ST_TLEN_HI:
            begin
                byte_v    = q_cmd.tlen[15:8];
                step_next = mqttpf_pkg::ST_TLEN_LO;
            end
            mqttpf_pkg::ST_TLEN_LO:
            begin
                byte_v    = q_cmd.tlen[7:0];
                step_next = mqttpf_pkg::ST_PID_HI;
                done      = !q_cmd.send_pid;
            end
            mqttpf_pkg::ST_DATA:
            begin
                byte_v    = q_cmd.data;
                step_next = mqttpf_pkg::ST_PID_HI;
                done      = !q_cmd.send_pid;
            end
            mqttpf_pkg::ST_PID_HI:
            begin
                byte_v    = q_cmd.pid[15:8];
                step_next = mqttpf_pkg::ST_PID_LO;
            end
            mqttpf_pkg::ST_PID_LO:
            begin
                byte_v = q_cmd.pid[7:0];
                done   = 1'b1;
            end
            default:
            begin
                byte_v = 8'd0;
                done   = 1'b1;
            end
        endcase
        busy_next = busy_reg;
        if (fire)
            busy_next = !done;
    end

    assign q_pop = fire && done;

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= mqttpf_pkg::ST_HDR;
            lidx_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (fire)
            begin
                step_reg <= step_next;
                lidx_reg <= lidx_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (fire)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ob_reg <= byte_v;
            ol_reg <= done && q_cmd.pkt_end;
            ot_reg <= (cur_step == mqttpf_pkg::ST_ERR);
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign last_byte = ol_reg;
    assign too_long  = ot_reg;

    a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> q_valid)
        else $error("sequencer busy with no queued command");
    a_pop_on_fire: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> fire)
        else $error("command popped without a byte sent");
    a_err_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_long) |-> (last_byte && out_byte == 8'd0))
        else $error("error result not marked as last");

endmodule

### hw/rtl/mqtt_publish_packet_framer_top.sv
// Top level of the MQTT PUBLISH packet framer.
// Instantiates mqttpf_front, mqttpf_cmd_fifo and mqttpf_back; uses mqttpf_pkg.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_data = max_packet_len (29 bits)
//  in       | in_valid/in_ready    | action, flags, packet_id, lengths, data_byte
//  out      | out_valid/out_ready  | out_byte, last_byte, too_long
//
// The output emits one byte per cycle from the back-end sequencer while the
// output is not stalled, which is what sets throughput: topic and payload items
// pass at one per cycle, a start item expands into 4 to 9 bytes, and a final
// topic byte followed by the packet id into 3.
// The input takes an item each cycle while the command queue has room.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled output holds its byte; the front keeps accepting until the queue fills.
module mqtt_publish_packet_framer_top #(
    parameter int CMD_FIFO_DEPTH = mqttpf_pkg::CMD_FIFO_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [28:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   action,
    input  logic         dup_flag,
    input  logic [1:0]   qos_level,
    input  logic         retain_flag,
    input  logic [15:0]  packet_id,
    input  logic [15:0]  topic_length,
    input  logic [27:0]  payload_length,
    input  logic [7:0]   data_byte,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         last_byte,
    output logic         too_long
);

    logic              q_full;
    logic              q_push;
    mqttpf_pkg::cmd_t  q_push_cmd;
    logic              q_pop;
    logic              q_valid;
    mqttpf_pkg::cmd_t  q_head;

    mqttpf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .dup_flag       (dup_flag),
        .qos_level      (qos_level),
        .retain_flag    (retain_flag),
        .packet_id      (packet_id),
        .topic_length   (topic_length),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_push_cmd)
    );

    mqttpf_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    mqttpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte),
        .too_long  (too_long)
    );

endmodule
